[rtl/dmx_pkg.sv]
// Shared types, constants and the slot role table of the stereo downmix.
// No dependencies; every other file imports it.
package dmx_pkg;

  localparam int unsigned NUM_SLOTS  = 9;
  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned SUM_W      = 20;   // nine samples at most per frame
  localparam int unsigned GAIN_W     = 13;
  localparam int unsigned PROD_W     = SUM_W + GAIN_W + 1;
  localparam int unsigned FRAC_SHIFT = 12;
  localparam int unsigned OUT_SHIFT  = 13;
  localparam int unsigned TOTAL_W    = PROD_W + 1;
  localparam int unsigned Q_DEPTH    = 2;
  localparam int unsigned Q_CNT_W    = 2;
  localparam int unsigned ADDR_W     = 5;
  localparam int unsigned DATA_W     = 32;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 13'd2896;

  typedef enum logic [1:0] {
    ROLE_LEFT,
    ROLE_RIGHT,
    ROLE_CENTER,
    ROLE_NONE
  } role_e;

  typedef enum logic [2:0] {
    REG_HAS_FC,
    REG_HAS_LFE,
    REG_HAS_BACK_PAIR,
    REG_HAS_BACK_CENTER,
    REG_HAS_SIDE_PAIR,
    REG_ACCUMULATE,
    REG_CENTER_GAIN
  } reg_e;

  typedef struct packed {
    logic              has_front_center;
    logic              has_lfe;
    logic              has_back_pair;
    logic              has_back_center;
    logic              has_side_pair;
    logic              accumulate_mode;
    logic [GAIN_W-1:0] center_gain;
  } cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    role_e                      role;
    logic                       last;
    logic signed [SAMPLE_W-1:0] prev_left;
    logic signed [SAMPLE_W-1:0] prev_right;
    logic                       end_of_block;
  } entry_t;

  // Channel role of each slot in full layout order FL FR FC LFE BL BR BC SL SR.
  function automatic role_e slot_role(input logic [SLOT_W-1:0] idx);
    role_e r;
    case (idx)
      4'd0, 4'd4, 4'd7: r = ROLE_LEFT;
      4'd1, 4'd5, 4'd8: r = ROLE_RIGHT;
      4'd2, 4'd3, 4'd6: r = ROLE_CENTER;
      default:          r = ROLE_NONE;
    endcase
    return r;
  endfunction

endpackage

[rtl/dmx_in_if.sv]
// Input channel of the downmix: one interleaved sample per beat.
// Depends on dmx_pkg for field widths.
interface dmx_in_if;
  import dmx_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic signed [SAMPLE_W-1:0] prev_left;
  logic signed [SAMPLE_W-1:0] prev_right;
  logic                       end_of_block;

  modport source (output valid, sample, prev_left, prev_right, end_of_block, input ready);
  modport sink   (input valid, sample, prev_left, prev_right, end_of_block, output ready);
endinterface

[rtl/dmx_out_if.sv]
// Output channel of the downmix: one stereo pair per beat.
// Depends on dmx_pkg for field widths.
interface dmx_out_if;
  import dmx_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] left_out;
  logic signed [SAMPLE_W-1:0] right_out;
  logic                       last_of_block;

  modport source (output valid, left_out, right_out, last_of_block, input ready);
  modport sink   (input valid, left_out, right_out, last_of_block, output ready);
endinterface

[rtl/dmx_cfg.sv]
// APB register file of the downmix: presence bits, accumulate mode, center gain.
// Depends on dmx_pkg.
module dmx_cfg import dmx_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t cfg_q, cfg_d;
  reg_e sel;
  logic wr_en;

  assign pready = 1'b1;
  assign sel    = reg_e'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_d  = cfg_q;
    prdata = '0;
    unique case (sel)
      REG_HAS_FC: begin
        prdata[0] = cfg_q.has_front_center;
        if (wr_en) cfg_d.has_front_center = pwdata[0];
      end
      REG_HAS_LFE: begin
        prdata[0] = cfg_q.has_lfe;
        if (wr_en) cfg_d.has_lfe = pwdata[0];
      end
      REG_HAS_BACK_PAIR: begin
        prdata[0] = cfg_q.has_back_pair;
        if (wr_en) cfg_d.has_back_pair = pwdata[0];
      end
      REG_HAS_BACK_CENTER: begin
        prdata[0] = cfg_q.has_back_center;
        if (wr_en) cfg_d.has_back_center = pwdata[0];
      end
      REG_HAS_SIDE_PAIR: begin
        prdata[0] = cfg_q.has_side_pair;
        if (wr_en) cfg_d.has_side_pair = pwdata[0];
      end
      REG_ACCUMULATE: begin
        prdata[0] = cfg_q.accumulate_mode;
        if (wr_en) cfg_d.accumulate_mode = pwdata[0];
      end
      REG_CENTER_GAIN: begin
        prdata[GAIN_W-1:0] = cfg_q.center_gain;
        if (wr_en) cfg_d.center_gain = pwdata[GAIN_W-1:0];
      end
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.has_front_center <= 1'b1;
      cfg_q.has_lfe          <= 1'b1;
      cfg_q.has_back_pair    <= 1'b1;
      cfg_q.has_back_center  <= 1'b0;
      cfg_q.has_side_pair    <= 1'b0;
      cfg_q.accumulate_mode  <= 1'b0;
      cfg_q.center_gain      <= GAIN_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/dmx_front.sv]
// Front end: accepts samples, tracks the slot position and tags each beat
// with its channel role and frame end. Depends on dmx_pkg and dmx_in_if.
module dmx_front import dmx_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  dmx_in_if.sink   in_if,
  input  logic     full_i,
  output logic     push_o,
  output entry_t   entry_o
);

  logic [SLOT_W-1:0]    slot_q, slot_d;
  logic [SLOT_W-1:0]    count;
  logic [NUM_SLOTS-1:0] en;
  role_e                role;
  logic                 last;

  assign en = {cfg_i.has_side_pair, cfg_i.has_side_pair, cfg_i.has_back_center,
               cfg_i.has_back_pair, cfg_i.has_back_pair, cfg_i.has_lfe,
               cfg_i.has_front_center, 1'b1, 1'b1};

  // Walk the enabled slots to find the role at the current position.
  always_comb begin
    count = '0;
    role  = ROLE_NONE;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (en[i]) begin
        if (count == slot_q) role = slot_role(SLOT_W'(i));
        count = count + SLOT_W'(1);
      end
    end
  end

  assign last   = ({1'b0, slot_q} + (SLOT_W+1)'(1)) >= {1'b0, count};
  assign slot_d = last ? '0 : slot_q + SLOT_W'(1);

  assign in_if.ready = !full_i;
  assign push_o      = in_if.valid && !full_i;

  always_comb begin
    entry_o.sample       = in_if.sample;
    entry_o.role         = role;
    entry_o.last         = last;
    entry_o.prev_left    = in_if.prev_left;
    entry_o.prev_right   = in_if.prev_right;
    entry_o.end_of_block = in_if.end_of_block;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else if (push_o) begin
      slot_q <= slot_d;
    end
  end

`ifndef SYNTHESIS
  a_slot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q < SLOT_W'(NUM_SLOTS))
    else $error("slot position past the full layout");
`endif

endmodule

[rtl/dmx_queue.sv]
// Two-entry queue between the front end and the mixing back end.
// Depends on dmx_pkg.
module dmx_queue import dmx_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   valid_o,
  output entry_t entry_o
);

  entry_t               mem_q [Q_DEPTH];
  logic                 wr_ptr_q, rd_ptr_q;
  logic [Q_CNT_W-1:0]   cnt_q, cnt_d;

  assign full_o  = cnt_q == Q_CNT_W'(Q_DEPTH);
  assign valid_o = cnt_q != '0;
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + Q_CNT_W'(1);
    else if (pop_i && !push_i) cnt_d = cnt_q - Q_CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i)  rd_ptr_q <= !rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= entry_i;
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= Q_CNT_W'(Q_DEPTH))
    else $error("queue count past depth");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty queue");
`endif

endmodule

[rtl/dmx_back.sv]
// Back end: accumulates left, right and center sums, then scales, shifts and
// saturates the frame result over three stages. Depends on dmx_pkg, dmx_out_if.
module dmx_back import dmx_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     q_valid_i,
  input  entry_t   q_entry_i,
  output logic     pop_o,
  dmx_out_if.source out_if
);

  logic signed [SUM_W-1:0]    lsum_q, rsum_q, csum_q;
  logic signed [SUM_W-1:0]    lsum_d, rsum_d, csum_d, s_ext;

  // stage A: final sums of a frame
  logic                       a_v_q;
  logic signed [SUM_W-1:0]    a_l_q, a_r_q, a_c_q;
  logic signed [SAMPLE_W-1:0] a_pl_q, a_pr_q;
  logic                       a_eob_q;

  // stage B: center product
  logic                       b_v_q;
  logic signed [SUM_W-1:0]    b_l_q, b_r_q;
  logic signed [PROD_W-1:0]   b_ctr_q;
  logic signed [SAMPLE_W-1:0] b_pl_q, b_pr_q;
  logic                       b_eob_q;

  // output register
  logic                       o_v_q;
  logic signed [SAMPLE_W-1:0] o_l_q, o_r_q;
  logic                       o_eob_q;

  logic out_free, b_adv, b_free, a_adv, a_free, frame_done;
  logic signed [PROD_W-1:0]   ctr;
  logic signed [SAMPLE_W-1:0] l_res, r_res;

  assign out_free   = !o_v_q || out_if.ready;
  assign b_adv      = b_v_q && out_free;
  assign b_free     = !b_v_q || b_adv;
  assign a_adv      = a_v_q && b_free;
  assign a_free     = !a_v_q || a_adv;
  assign pop_o      = q_valid_i && (!q_entry_i.last || a_free);
  assign frame_done = pop_o && q_entry_i.last;

  assign s_ext = SUM_W'(q_entry_i.sample);

  always_comb begin
    lsum_d = lsum_q;
    rsum_d = rsum_q;
    csum_d = csum_q;
    case (q_entry_i.role)
      ROLE_LEFT:   lsum_d = lsum_q + s_ext;
      ROLE_RIGHT:  rsum_d = rsum_q + s_ext;
      ROLE_CENTER: csum_d = csum_q + s_ext;
      default: ;
    endcase
  end

  assign ctr = PROD_W'(a_c_q * $signed({1'b0, cfg_i.center_gain}));

  function automatic logic signed [SAMPLE_W-1:0] mix_out(
    input logic signed [SUM_W-1:0]    part,
    input logic signed [PROD_W-1:0]   ctr_in,
    input logic signed [SAMPLE_W-1:0] prev,
    input logic                       acc
  );
    logic signed [TOTAL_W-1:0]            total;
    logic signed [TOTAL_W-OUT_SHIFT-1:0]  shifted;
    logic signed [TOTAL_W-OUT_SHIFT:0]    sum;
    total   = TOTAL_W'($signed({part, {FRAC_SHIFT{1'b0}}})) + TOTAL_W'(ctr_in);
    // floor shift: drop the low bits of the two's complement sum
    shifted = total[TOTAL_W-1:OUT_SHIFT];
    sum     = (TOTAL_W-OUT_SHIFT+1)'(shifted);
    if (acc) sum = sum + (TOTAL_W-OUT_SHIFT+1)'(prev);
    if (sum > (TOTAL_W-OUT_SHIFT+1)'(32767)) return 16'sh7fff;
    if (sum < -(TOTAL_W-OUT_SHIFT+1)'(32768)) return 16'sh8000;
    return sum[SAMPLE_W-1:0];
  endfunction

  assign l_res = mix_out(b_l_q, b_ctr_q, b_pl_q, cfg_i.accumulate_mode);
  assign r_res = mix_out(b_r_q, b_ctr_q, b_pr_q, cfg_i.accumulate_mode);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lsum_q <= '0;
      rsum_q <= '0;
      csum_q <= '0;
      a_v_q  <= 1'b0;
      b_v_q  <= 1'b0;
      o_v_q  <= 1'b0;
    end else begin
      if (pop_o) begin
        // clear the partial sums when a frame closes
        lsum_q <= q_entry_i.last ? '0 : lsum_d;
        rsum_q <= q_entry_i.last ? '0 : rsum_d;
        csum_q <= q_entry_i.last ? '0 : csum_d;
      end
      if (a_free)   a_v_q <= frame_done;
      if (b_free)   b_v_q <= a_v_q;
      if (out_free) o_v_q <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_done) begin
      a_l_q   <= lsum_d;
      a_r_q   <= rsum_d;
      a_c_q   <= csum_d;
      a_pl_q  <= q_entry_i.prev_left;
      a_pr_q  <= q_entry_i.prev_right;
      a_eob_q <= q_entry_i.end_of_block;
    end
    if (a_adv) begin
      b_l_q   <= a_l_q;
      b_r_q   <= a_r_q;
      b_ctr_q <= ctr;
      b_pl_q  <= a_pl_q;
      b_pr_q  <= a_pr_q;
      b_eob_q <= a_eob_q;
    end
    if (b_adv) begin
      o_l_q   <= l_res;
      o_r_q   <= r_res;
      o_eob_q <= b_eob_q;
    end
  end

  assign out_if.valid         = o_v_q;
  assign out_if.left_out      = o_l_q;
  assign out_if.right_out     = o_r_q;
  assign out_if.last_of_block = o_eob_q;

`ifndef SYNTHESIS
  a_sums_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_done |=> (lsum_q == '0) && (rsum_q == '0) && (csum_q == '0))
    else $error("partial sums not cleared at frame end");
  a_b_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_adv |=> o_v_q)
    else $error("result lost between product stage and output");
  a_a_to_b: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_adv |=> b_v_q)
    else $error("frame sums lost between sum and product stage");
`endif

endmodule

[rtl/multichannel_stereo_downmix.sv]
// Top level of the surround to stereo downmix: register file, front end,
// queue and back end. Depends on dmx_pkg, dmx_in_if, dmx_out_if and submodules.
//
// Takes one interleaved 16-bit sample per clock while ready is high, slots in
// order FL, FR, FC, LFE, BL, BR, BC, SL, SR with only the enabled slots
// present, and emits one saturated stereo pair per frame. Sustained rate is
// one sample per cycle while the sink takes each pair. A frame's pair moves
// through queue and sum stage, center gain multiply, shift and saturate.
// The output register holds a pair while the sink stalls, and the two-entry
// queue lets samples keep flowing meanwhile until the stall reaches the input.
// Registers sit at byte address 4*index; write them only while no frame is
// in flight.
module multichannel_stereo_downmix import dmx_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  dmx_in_if.sink            in_if,
  dmx_out_if.source         out_if,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t   cfg;
  logic   push, full, q_valid, pop;
  entry_t push_entry, q_entry;

  dmx_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dmx_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .in_if   (in_if),
    .full_i  (full),
    .push_o  (push),
    .entry_o (push_entry)
  );

  dmx_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .entry_o (q_entry)
  );

  dmx_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .q_valid_i (q_valid),
    .q_entry_i (q_entry),
    .pop_o     (pop),
    .out_if    (out_if)
  );

endmodule
